// File: design/pixel_color_class_counter_unit_macros.svh
// Assertion macros shared by the pixel color class counter RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef PIXEL_COLOR_CLASS_COUNTER_UNIT_MACROS_SVH
`define PIXEL_COLOR_CLASS_COUNTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pcc_pkg.sv
// Package for the pixel color class counter: widths, codes, queue entry type
// and the output saturation function. No dependencies.
package pcc_pkg;

  localparam int LEVEL_W   = 8;
  localparam int COUNT_BITS = 16;
  localparam int OUT_W     = 16;
  localparam int SAT_W     = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;
  localparam int NUM_CLASS = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  // Queue between classifier and tally stage (power of two)
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLACK_MAX_BLUE = 3'd0,
    CFG_BLACK_SPREAD   = 3'd1,
    CFG_WHITE_MIN_BLUE = 3'd2,
    CFG_WHITE_SPREAD   = 3'd3,
    CFG_BLUE_MARGIN    = 3'd4,
    CFG_YELLOW_MARGIN  = 3'd5
  } cfg_idx_t;

  // Class positions within the hit vector, in result order
  typedef enum logic [2:0] {
    CLS_RED    = 3'd0,
    CLS_BLUE   = 3'd1,
    CLS_BLACK  = 3'd2,
    CLS_YELLOW = 3'd3,
    CLS_WHITE  = 3'd4
  } cls_t;

  typedef logic [LEVEL_W-1:0]    level_t;
  typedef logic [COUNT_BITS-1:0] tally_t;
  typedef logic [OUT_W-1:0]      count_t;

  // One classified pixel waiting for the tally stage
  typedef struct packed {
    logic [NUM_CLASS-1:0] hit;
    logic                 last;
  } pcc_entry_t;

  // Clamp a tally to the output field width
  function automatic count_t sat_out(tally_t t);
    logic [SAT_W-1:0] wide;
    wide = SAT_W'(t);
    if (wide > SAT_W'({OUT_W{1'b1}})) begin
      return {OUT_W{1'b1}};
    end
    return OUT_W'(wide);
  endfunction

endpackage

// File: design/pcc_pix_if.sv
// Pixel channel: valid/ready handshake carrying one BGR pixel per beat.
// Depends on pcc_pkg.
interface pcc_pix_if;
  import pcc_pkg::*;

  logic   valid;
  logic   ready;
  level_t blue_level;
  level_t green_level;
  level_t red_level;
  logic   last_pixel;

  modport source (output valid, blue_level, green_level, red_level, last_pixel,
                  input ready);
  modport sink   (input valid, blue_level, green_level, red_level, last_pixel,
                  output ready);
endinterface

// File: design/pcc_cnt_if.sv
// Result channel: valid/ready handshake carrying five class counts per beat.
// Depends on pcc_pkg.
interface pcc_cnt_if;
  import pcc_pkg::*;

  logic   valid;
  logic   ready;
  count_t red_count;
  count_t blue_count;
  count_t black_count;
  count_t yellow_count;
  count_t white_count;

  modport source (output valid, red_count, blue_count, black_count, yellow_count,
                  white_count, input ready);
  modport sink   (input valid, red_count, blue_count, black_count, yellow_count,
                  white_count, output ready);
endinterface

// File: design/pcc_front.sv
// Front stage: holds the threshold registers, accepts pixel beats and
// classifies them into the queue. Depends on pcc_pkg and pcc_pix_if.
module pcc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcc_pkg::CFG_DATA_W-1:0] cfg_data,
  pcc_pix_if.sink                       pix,
  input  logic                          q_full,
  output logic                          push,
  output pcc_pkg::pcc_entry_t           push_data
);
  import pcc_pkg::*;

  level_t black_max_blue_r, black_max_blue_nxt;
  level_t black_spread_r, black_spread_nxt;
  level_t white_min_blue_r, white_min_blue_nxt;
  level_t white_spread_r, white_spread_nxt;
  level_t blue_margin_r, blue_margin_nxt;
  level_t yellow_margin_r, yellow_margin_nxt;

  level_t b, g, r, mx;
  level_t gap_bg, gap_br, gap_rg;
  logic [12:0] red_x10, gb_x13;
  logic [8:0]  gb_sum;
  logic [NUM_CLASS-1:0] hit;

  function automatic level_t abs_gap(level_t x, level_t y);
    return (x > y) ? (x - y) : (y - x);
  endfunction

  // Threshold register writes; unknown indexes are dropped
  always_comb begin
    black_max_blue_nxt = black_max_blue_r;
    black_spread_nxt   = black_spread_r;
    white_min_blue_nxt = white_min_blue_r;
    white_spread_nxt   = white_spread_r;
    blue_margin_nxt    = blue_margin_r;
    yellow_margin_nxt  = yellow_margin_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BLACK_MAX_BLUE: black_max_blue_nxt = level_t'(cfg_data);
        CFG_BLACK_SPREAD:   black_spread_nxt   = level_t'(cfg_data);
        CFG_WHITE_MIN_BLUE: white_min_blue_nxt = level_t'(cfg_data);
        CFG_WHITE_SPREAD:   white_spread_nxt   = level_t'(cfg_data);
        CFG_BLUE_MARGIN:    blue_margin_nxt    = level_t'(cfg_data);
        CFG_YELLOW_MARGIN:  yellow_margin_nxt  = level_t'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      black_max_blue_r <= 8'd100;
      black_spread_r   <= 8'd25;
      white_min_blue_r <= 8'd128;
      white_spread_r   <= 8'd20;
      blue_margin_r    <= 8'd10;
      yellow_margin_r  <= 8'd20;
    end else begin
      black_max_blue_r <= black_max_blue_nxt;
      black_spread_r   <= black_spread_nxt;
      white_min_blue_r <= white_min_blue_nxt;
      white_spread_r   <= white_spread_nxt;
      blue_margin_r    <= blue_margin_nxt;
      yellow_margin_r  <= yellow_margin_nxt;
    end
  end

  // Classification of the incoming pixel
  always_comb begin
    b = pix.blue_level;
    g = pix.green_level;
    r = pix.red_level;
    mx = (g > r) ? g : r;
    gap_bg = abs_gap(b, g);
    gap_br = abs_gap(b, r);
    gap_rg = abs_gap(r, g);
    // 10*r > 13*(g+b): integer form of the 1.3 ratio
    gb_sum  = {1'b0, g} + {1'b0, b};
    red_x10 = 13'(r) * 13'd10;
    gb_x13  = 13'(gb_sum) * 13'd13;

    hit = '0;
    hit[CLS_RED]   = red_x10 > gb_x13;
    hit[CLS_BLUE]  = (b > mx) && ((b - mx) > blue_margin_r);
    hit[CLS_BLACK] = (b <= black_max_blue_r) && (gap_bg < black_spread_r) &&
                     (gap_br < black_spread_r) && (gap_rg < black_spread_r);
    hit[CLS_YELLOW] = (g > b) && ((g - b) > yellow_margin_r) &&
                      (r > b) && ((r - b) > yellow_margin_r);
    hit[CLS_WHITE] = (b > white_min_blue_r) && (gap_bg < white_spread_r) &&
                     (gap_br < white_spread_r) && (gap_rg < white_spread_r);
  end

  // Beat is taken whenever the queue has room
  assign pix.ready      = !q_full;
  assign push           = pix.valid && !q_full;
  assign push_data.hit  = hit;
  assign push_data.last = pix.last_pixel;

endmodule

// File: design/pcc_queue.sv
// Short FIFO of classified pixels between front and tally stages.
// Depends on pcc_pkg and the assertion macro header.
`include "pixel_color_class_counter_unit_macros.svh"

module pcc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pcc_pkg::pcc_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output pcc_pkg::pcc_entry_t head
);
  import pcc_pkg::*;

  pcc_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  `PCC_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= QCNT_W'(QDEPTH), "queue fill over depth")
  `PCC_ASSERT_NOW(a_pop_nonempty, pop, cnt_r != '0, "pop from empty queue")
  `PCC_ASSERT_NEXT(a_push_grows, push && !pop, cnt_r == QCNT_W'($past(cnt_r) + 1'b1), "push lost")

endmodule

// File: design/pcc_back.sv
// Tally stage: drains the queue into five saturating tallies and loads the
// result register on a last pixel. Depends on pcc_pkg, pcc_cnt_if, macros.
`include "pixel_color_class_counter_unit_macros.svh"

module pcc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  pcc_pkg::pcc_entry_t head,
  output logic                pop,
  pcc_cnt_if.source           cnt
);
  import pcc_pkg::*;

  tally_t tally_r   [NUM_CLASS];
  tally_t tally_nxt [NUM_CLASS];
  tally_t bumped    [NUM_CLASS];
  count_t out_cnt_r   [NUM_CLASS];
  count_t out_cnt_nxt [NUM_CLASS];
  logic   out_valid_r, out_valid_nxt;

  // A last pixel waits until the result register is free
  assign pop = head_valid && (!head.last || !out_valid_r || cnt.ready);

  // Saturating bump, clear after a last pixel
  always_comb begin
    for (int i = 0; i < NUM_CLASS; i++) begin
      bumped[i] = (head.hit[i] && (tally_r[i] != '1)) ? tally_r[i] + 1'b1 : tally_r[i];
      tally_nxt[i]   = tally_r[i];
      out_cnt_nxt[i] = out_cnt_r[i];
      if (pop) begin
        tally_nxt[i] = head.last ? '0 : bumped[i];
        if (head.last) begin
          out_cnt_nxt[i] = sat_out(bumped[i]);
        end
      end
    end
  end

  // Result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop && head.last) begin
      out_valid_nxt = 1'b1;
    end else if (cnt.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CLASS; i++) begin
        tally_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NUM_CLASS; i++) begin
        tally_r[i] <= tally_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_CLASS; i++) begin
      out_cnt_r[i] <= out_cnt_nxt[i];
    end
  end

  assign cnt.valid        = out_valid_r;
  assign cnt.red_count    = out_cnt_r[CLS_RED];
  assign cnt.blue_count   = out_cnt_r[CLS_BLUE];
  assign cnt.black_count  = out_cnt_r[CLS_BLACK];
  assign cnt.yellow_count = out_cnt_r[CLS_YELLOW];
  assign cnt.white_count  = out_cnt_r[CLS_WHITE];

  `PCC_ASSERT_NOW(a_no_overwrite, pop && head.last, !out_valid_r || cnt.ready, "result overwritten")
  `PCC_ASSERT_NEXT(a_result_up, pop && head.last, out_valid_r, "result not raised")
  `PCC_ASSERT_NEXT(a_tally_clear, pop && head.last, tally_r[CLS_RED] == '0 && tally_r[CLS_WHITE] == '0, "tallies not cleared")

endmodule

// File: design/pixel_color_class_counter_unit.sv
// Top level of the pixel color class counter.
// Depends on pcc_pkg, pcc_pix_if, pcc_cnt_if, pcc_front, pcc_queue, pcc_back.
//
// Counts BGR pixels in five overlapping classes (red, blue, black, yellow,
// white) and, on the pixel marked last, delivers all five counts as one beat
// and restarts counting. Pixels are taken at one per clock: the classifier
// writes each pixel's class flags into a four-entry queue in the cycle it is
// accepted, and the tally stage drains one entry per clock. A count beat is
// loaded into an output register as its last pixel leaves the queue and
// sits there while counting of the next region goes on; only a second last
// pixel that reaches the tally stage while that register is still held stops
// the drain, and input ready drops once the queue fills. Tallies saturate. The
// user must write thresholds via the cfg port while the block is idle; the block does not enforce it.
module pixel_color_class_counter_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcc_pkg::CFG_DATA_W-1:0] cfg_data,
  pcc_pix_if.sink                        in_pix,
  pcc_cnt_if.source                      out_cnt
);
  import pcc_pkg::*;

  logic       push, pop, q_full, head_valid;
  pcc_entry_t push_data, head;

  // Classifier and threshold registers
  pcc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (in_pix),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // Decoupling queue
  pcc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Tallies and result register
  pcc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .cnt        (out_cnt)
  );

endmodule
